>>> hdl/alle_pkg.sv
// Shared constants for the array linked-list engine: opcodes, status codes,
// stream word widths and parameter defaults. No dependencies.
`default_nettype none
package alle_pkg;
    localparam int POOL_SIZE_DEF  = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W     = 3;
    localparam int FIELD_W  = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 5;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_INS_HEAD   = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_TAIL   = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_HEAD   = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_TAIL   = 3'd5;
    localparam logic [OP_W-1:0] OP_DEL_AFTER  = 3'd6;
    localparam logic [OP_W-1:0] OP_DEL_BEFORE = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;
endpackage
`default_nettype wire

>>> hdl/array_linked_list_engine_top.sv
// Top level of the array linked-list engine: sequencer, list walker and
// output register. Depends on alle_pkg and alle_ram.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata; each carries an opcode,
//   a search key and a value to store. Every input word yields exactly one
//   result word on m_tvalid/m_tready/m_tdata with a status and the pool slot
//   that was filled or freed (zero unless the status is ok).
//   The block works on one word at a time. Each word passes through the
//   free-list read, a walk over the list (skipped for insert at head or an
//   empty list), the write states WR1 and WR2 and the output load. Ready
//   returns in the cycle after the result is loaded. The walk reads one
//   node per cycle from the link and value memories, whose single
//   registered read port sets that rate.
//   The result sits in an output register; a new input word is taken while
//   it waits, and the sequencer holds in its final state only if the
//   receiver has not taken the previous result by then.
//   Reset (aresetn low, synchronous) empties the list and puts every node on
//   the free list in order; it needs no clearing pass, because a fill count
//   marks the nodes whose links have never been written.
`default_nettype none
module array_linked_list_engine_top
    import alle_pkg::*;
#(
    parameter int POOL_SIZE  = POOL_SIZE_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // opcode [2:0], key [34:3], value [66:35], zero fill above
    input  wire logic [S_DATA_W-1:0] s_tdata,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // status [1:0], slot [6:2], zero fill above
    output logic      [M_DATA_W-1:0] m_tdata
);
    localparam int IW = $clog2(POOL_SIZE);
    localparam int LW = IW + 1;
    localparam logic [LW-1:0] NULL_IDX = {LW{1'b1}};
    localparam logic [LW-1:0] POOL_L   = LW'(POOL_SIZE);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FREE = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_WR1  = 3'd3;
    localparam logic [2:0] S_WR2  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [OP_W-1:0] op_reg, op_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next, val_reg, val_next;
    logic [LW-1:0] head_reg, head_next, free_reg, free_next, fnext_reg, fnext_next;
    logic [LW-1:0] hw_reg, hw_next;
    logic [LW-1:0] c_reg, c_next, p_reg, p_next, pp_reg, pp_next;
    logic found_reg, found_next;
    logic [LW-1:0] rd_idx_reg, rd_addr;
    logic le1_reg, le1_next, le2_reg, le2_next, ve_reg, ve_next;
    logic [LW-1:0] la1_reg, la1_next, ld1_reg, ld1_next;
    logic [LW-1:0] la2_reg, la2_next, ld2_reg, ld2_next, va_reg, va_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;

    logic [DATA_WIDTH-1:0] rv;
    logic [LW-1:0] rl, lnk, fn_use;
    logic lnk_null, fnull, empty, match, accept;
    logic fin, take_go, ins_head_go, advance;
    logic [STATUS_W-1:0] st;
    logic [LW-1:0] slot_idx;

    logic link_we, val_we;
    logic [IW-1:0] link_wa;
    logic [LW-1:0] link_wd;

    alle_ram #(.DEPTH(POOL_SIZE), .WIDTH(DATA_WIDTH)) u_value_ram (
        .aclk    (aclk),
        .wr_en   (val_we),
        .wr_addr (va_reg[IW-1:0]),
        .wr_data (val_reg),
        .rd_addr (rd_addr[IW-1:0]),
        .rd_data (rv)
    );

    alle_ram #(.DEPTH(POOL_SIZE), .WIDTH(LW)) u_link_ram (
        .aclk    (aclk),
        .wr_en   (link_we),
        .wr_addr (link_wa),
        .wr_data (link_wd),
        .rd_addr (rd_addr[IW-1:0]),
        .rd_data (rl)
    );

    // Nodes at or above the fill count still carry their reset chain link.
    always_comb begin
        if (rd_idx_reg >= hw_reg) begin
            lnk = (rd_idx_reg + LW'(1) >= POOL_L) ? NULL_IDX : rd_idx_reg + LW'(1);
        end else begin
            lnk = (rl >= POOL_L) ? NULL_IDX : rl;
        end
    end

    assign lnk_null = (lnk >= POOL_L);
    assign fnull    = (free_reg >= POOL_L);
    assign empty    = (head_reg >= POOL_L);
    assign match    = (rv == key_reg);
    assign fn_use   = (state_reg == S_FREE) ? lnk : fnext_reg;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        case (state_reg)
            S_FREE:  rd_addr = head_reg;
            S_WALK:  rd_addr = lnk;
            default: rd_addr = free_reg;
        endcase
    end

    assign link_we = ((state_reg == S_WR1) && le1_reg) || ((state_reg == S_WR2) && le2_reg);
    assign link_wa = (state_reg == S_WR2) ? la2_reg[IW-1:0] : la1_reg[IW-1:0];
    assign link_wd = (state_reg == S_WR2) ? ld2_reg : ld1_reg;
    assign val_we  = (state_reg == S_WR1) && ve_reg;

    always_comb begin
        state_next = state_reg;
        op_next = op_reg; key_next = key_reg; val_next = val_reg;
        head_next = head_reg; free_next = free_reg; fnext_next = fnext_reg;
        hw_next = hw_reg;
        c_next = c_reg; p_next = p_reg; pp_next = pp_reg; found_next = found_reg;
        le1_next = le1_reg; le2_next = le2_reg; ve_next = ve_reg;
        la1_next = la1_reg; ld1_next = ld1_reg; la2_next = la2_reg; ld2_next = ld2_reg;
        va_next = va_reg;
        status_next = status_reg; slot_next = slot_reg;
        m_valid_next = m_valid_reg; m_status_next = m_status_reg; m_slot_next = m_slot_reg;
        fin = 1'b0; take_go = 1'b0; ins_head_go = 1'b0; advance = 1'b0;
        st = ST_OK; slot_idx = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next  = s_tdata[OP_W-1:0];
                    key_next = DATA_WIDTH'(s_tdata[OP_W +: FIELD_W]);
                    val_next = DATA_WIDTH'(s_tdata[OP_W+FIELD_W +: FIELD_W]);
                    le1_next = 1'b0; le2_next = 1'b0; ve_next = 1'b0;
                    state_next = S_FREE;
                end
            end
            S_FREE: begin
                fnext_next = lnk;
                c_next = head_reg; p_next = NULL_IDX; pp_next = NULL_IDX;
                found_next = 1'b0;
                case (op_reg)
                    OP_INS_HEAD: ins_head_go = 1'b1;
                    OP_INS_TAIL: begin
                        if (empty) begin
                            ins_head_go = 1'b1;
                        end else if (fnull) begin
                            fin = 1'b1; st = ST_FULL;
                        end else begin
                            state_next = S_WALK;
                        end
                    end
                    default: begin
                        if (empty) begin
                            fin = 1'b1; st = ST_EMPTY;
                        end else begin
                            state_next = S_WALK;
                        end
                    end
                endcase
            end
            S_WALK: begin
                case (op_reg)
                    OP_INS_TAIL: begin
                        if (lnk_null) begin
                            take_go = 1'b1; fin = 1'b1; ve_next = 1'b1; va_next = free_reg;
                            le1_next = 1'b1; la1_next = c_reg; ld1_next = free_reg;
                            le2_next = 1'b1; la2_next = free_reg; ld2_next = NULL_IDX;
                            slot_idx = free_reg;
                        end else begin
                            advance = 1'b1;
                        end
                    end
                    OP_INS_AFTER: begin
                        if (match) begin
                            fin = 1'b1;
                            if (fnull) begin
                                st = ST_FULL;
                            end else begin
                                take_go = 1'b1; ve_next = 1'b1; va_next = free_reg;
                                le1_next = 1'b1; la1_next = free_reg; ld1_next = lnk;
                                le2_next = 1'b1; la2_next = c_reg; ld2_next = free_reg;
                                slot_idx = free_reg;
                            end
                        end else if (lnk_null) begin
                            fin = 1'b1; st = ST_NOTFOUND;
                        end else begin
                            advance = 1'b1;
                        end
                    end
                    OP_INS_BEFORE: begin
                        if (match && (p_reg == NULL_IDX)) begin
                            ins_head_go = 1'b1;
                        end else if (match) begin
                            fin = 1'b1;
                            if (fnull) begin
                                st = ST_FULL;
                            end else begin
                                take_go = 1'b1; ve_next = 1'b1; va_next = free_reg;
                                le1_next = 1'b1; la1_next = free_reg; ld1_next = c_reg;
                                le2_next = 1'b1; la2_next = p_reg; ld2_next = free_reg;
                                slot_idx = free_reg;
                            end
                        end else if (lnk_null) begin
                            fin = 1'b1; st = ST_NOTFOUND;
                        end else begin
                            advance = 1'b1;
                        end
                    end
                    OP_DEL_HEAD: begin
                        fin = 1'b1; head_next = lnk;
                        le1_next = 1'b1; la1_next = c_reg; ld1_next = free_reg;
                        free_next = c_reg; slot_idx = c_reg;
                    end
                    OP_DEL_TAIL: begin
                        if (lnk_null) begin
                            fin = 1'b1; free_next = c_reg; slot_idx = c_reg;
                            if (p_reg == NULL_IDX) begin
                                head_next = NULL_IDX;
                                le1_next = 1'b1; la1_next = c_reg; ld1_next = free_reg;
                            end else begin
                                le1_next = 1'b1; la1_next = p_reg; ld1_next = NULL_IDX;
                                le2_next = 1'b1; la2_next = c_reg; ld2_next = free_reg;
                            end
                        end else begin
                            advance = 1'b1;
                        end
                    end
                    OP_DEL_AFTER: begin
                        // Once the key is found the walk goes one node further,
                        // so that the successor's own link is at hand.
                        if (found_reg) begin
                            fin = 1'b1; free_next = c_reg; slot_idx = c_reg;
                            le1_next = 1'b1; la1_next = p_reg; ld1_next = lnk;
                            le2_next = 1'b1; la2_next = c_reg; ld2_next = free_reg;
                        end else if (lnk_null) begin
                            fin = 1'b1; st = ST_NOTFOUND;
                        end else begin
                            found_next = match;
                            advance = 1'b1;
                        end
                    end
                    default: begin
                        // Delete before key: the head itself is never a match.
                        if (match && (p_reg != NULL_IDX)) begin
                            fin = 1'b1; free_next = p_reg; slot_idx = p_reg;
                            if (pp_reg == NULL_IDX) begin
                                head_next = c_reg;
                                le1_next = 1'b1; la1_next = p_reg; ld1_next = free_reg;
                            end else begin
                                le1_next = 1'b1; la1_next = pp_reg; ld1_next = c_reg;
                                le2_next = 1'b1; la2_next = p_reg; ld2_next = free_reg;
                            end
                        end else if (lnk_null) begin
                            fin = 1'b1; st = ST_NOTFOUND;
                        end else begin
                            advance = 1'b1;
                        end
                    end
                endcase
            end
            S_WR1: state_next = S_WR2;
            S_WR2: state_next = S_OUT;
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_slot_next   = slot_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (ins_head_go) begin
            fin = 1'b1;
            if (fnull) begin
                st = ST_FULL;
            end else begin
                take_go = 1'b1; ve_next = 1'b1; va_next = free_reg;
                le1_next = 1'b1; la1_next = free_reg; ld1_next = head_reg;
                head_next = free_reg; slot_idx = free_reg;
            end
        end

        if (take_go) begin
            free_next = fn_use;
            if (free_reg == hw_reg) begin
                hw_next = hw_reg + LW'(1);
            end
        end

        if (advance) begin
            pp_next = p_reg; p_next = c_reg; c_next = lnk;
        end

        if (fin) begin
            status_next = st;
            slot_next   = (st == ST_OK) ? SLOT_W'(slot_idx) : '0;
            state_next  = S_WR1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= NULL_IDX;
            free_reg    <= '0;
            hw_reg      <= '0;
            m_valid_reg <= 1'b0;
            le1_reg     <= 1'b0;
            le2_reg     <= 1'b0;
            ve_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            free_reg    <= free_next;
            hw_reg      <= hw_next;
            m_valid_reg <= m_valid_next;
            le1_reg     <= le1_next;
            le2_reg     <= le2_next;
            ve_reg      <= ve_next;
        end
        op_reg <= op_next; key_reg <= key_next; val_reg <= val_next;
        fnext_reg <= fnext_next;
        c_reg <= c_next; p_reg <= p_next; pp_reg <= pp_next; found_reg <= found_next;
        rd_idx_reg <= rd_addr;
        la1_reg <= la1_next; ld1_reg <= ld1_next;
        la2_reg <= la2_next; ld2_reg <= ld2_next; va_reg <= va_next;
        status_reg <= status_next; slot_reg <= slot_next;
        m_status_reg <= m_status_next; m_slot_reg <= m_slot_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_slot_reg, m_status_reg};

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (state_reg == S_IDLE))
        else $error("ready raised outside idle");
    a_accept_free: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_FREE))
        else $error("accepted word did not start the free-list read");
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        hw_reg <= POOL_L)
        else $error("fill count beyond pool size");
    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg != ST_OK)) |-> (m_slot_reg == '0))
        else $error("nonzero slot on a failed operation");
`endif
endmodule
`default_nettype wire

>>> hdl/alle_ram.sv
// Simple dual-port RAM: one write port, one registered read port.
// Used for the node value and node link stores. No dependencies.
`default_nettype none
module alle_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire
